// File: src/oriented_box_point_collision_top_macros.svh
`ifndef ORIENTED_BOX_POINT_COLLISION_TOP_MACROS_SVH
`define ORIENTED_BOX_POINT_COLLISION_TOP_MACROS_SVH

// condition holds at every edge out of reset
`define OBPC_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle
`define OBPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the next cycle
`define OBPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/obpc_pkg.sv
package obpc_pkg;

    localparam int COORD_BITS = 32;
    localparam int ROAD_CAP   = 4096;
    localparam int OBS_CAP    = 4096;
    localparam int ROAD_AW    = $clog2(ROAD_CAP);
    localparam int OBS_AW     = $clog2(OBS_CAP);
    localparam int ROAD_CW    = $clog2(ROAD_CAP + 1);
    localparam int OBS_CW     = $clog2(OBS_CAP + 1);
    localparam int SCAN_CW    = (ROAD_CW > OBS_CW) ? ROAD_CW : OBS_CW;

    localparam int IN_COORD_W  = 32;
    localparam int HEAD_W      = 16;
    localparam int IDX_W       = 16;
    localparam int CMD_W       = 3;
    localparam int REG_W       = 16;
    localparam int APB_W       = 32;
    localparam int ADDR_W      = 5;
    localparam int IN_TDATA_W  = 2 * IN_COORD_W + HEAD_W + IDX_W;
    localparam int OUT_FIELD_W = 1 + IDX_W + 1;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // fixed point datapath widths
    localparam int MUL_W  = 33;
    localparam int LEN_W  = 18;
    localparam int PROD_W = 50;
    localparam int OFS_W  = PROD_W + 1;
    localparam int CORN_W = COORD_BITS + 3;
    localparam int EDGE_W = 22;
    localparam int PD_W   = CORN_W + 1;
    localparam int XP_W   = EDGE_W + PD_W;
    localparam int QSHIFT = 30;

    localparam logic signed [MUL_W-1:0] SC1 = 33'sd1686629713;
    localparam logic signed [MUL_W-1:0] SC3 = 33'sd693598668;
    localparam logic signed [MUL_W-1:0] SC5 = 33'sd85569306;
    localparam logic signed [MUL_W-1:0] SC7 = 33'sd5026995;
    localparam logic signed [MUL_W-1:0] SC9 = 33'sd172274;
    localparam logic signed [MUL_W-1:0] Q30_ONE = 33'sd1073741824;
    localparam logic [14:0] QUARTER = 15'd16384;

    typedef enum logic [2:0] {
        CMD_CLR_ROAD  = 3'd0,
        CMD_CLR_OBS   = 3'd1,
        CMD_LOAD_ROAD = 3'd2,
        CMD_LOAD_OBS  = 3'd3,
        CMD_CHECK     = 3'd4,
        CMD_PATH      = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLR_ROAD,
        OP_CLR_OBS,
        OP_LOAD_ROAD,
        OP_LOAD_OBS,
        OP_CHECK,
        OP_PATH
    } t_op;

    typedef enum logic [2:0] {
        REG_FRONT       = 3'd0,
        REG_SIDE        = 3'd1,
        REG_REAR_ROAD   = 3'd2,
        REG_REAR_OBS    = 3'd3,
        REG_MARGIN_ROAD = 3'd4,
        REG_MARGIN_OBS  = 3'd5,
        REG_MARGIN_ERR  = 3'd6
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRIG,
        ST_CPROD,
        ST_CORNER,
        ST_EDGE,
        ST_SCAN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [REG_W-1:0] front_length;
        logic [REG_W-1:0] side_half_width;
        logic [REG_W-1:0] rear_length_road;
        logic [REG_W-1:0] rear_length_obstacle;
        logic [REG_W-1:0] margin_road;
        logic [REG_W-1:0] margin_obstacle;
        logic [REG_W-1:0] margin_error;
    } t_cfg;

    typedef struct packed {
        t_op                           op;
        logic signed [COORD_BITS-1:0]  pos_x;
        logic signed [COORD_BITS-1:0]  pos_y;
        logic [HEAD_W-1:0]             heading;
        logic [IDX_W-1:0]              pose_index;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_out;

endpackage

// File: src/oriented_box_point_collision_top.sv
// oriented box point collision checker
// input stream: tuser carries the command, tdata the point or pose and pose index;
// a transaction is taken when tvalid and tready are both high
// load commands append a point to the road or obstacle store, clear commands empty it,
// check and path check test every stored point against the vehicle box at the pose
// output stream: one transaction per input, collided, echoed index and drop status
// loads, clears and unknown commands: popped from the queue while idle, result registered on the pop
// checks: sine, cosine and the corner products share one multiplier, and the scan makes
// one memory read per stored point
// items are worked one at a time; a two-entry queue takes new input while busy
// configuration: the user must write registers over the apb port only while the block is idle; not enforced
// reset clears both point counts, the queue and all configuration registers; no memory sweep
// a stalled output holds its result and the back end waits, the queue then fills
// and input tready falls
module oriented_box_point_collision_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // pos_x, pos_y, heading, pose_index
    input  logic [obpc_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // command
    input  logic [obpc_pkg::CMD_W-1:0]          i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // collided, echo_index, status, zero fill
    output logic [obpc_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [obpc_pkg::ADDR_W-1:0]         paddr,
    input  logic [obpc_pkg::APB_W-1:0]          pwdata,
    output logic [obpc_pkg::APB_W-1:0]          prdata,
    output logic                                pready
);

    localparam int XW = obpc_pkg::IN_COORD_W;
    localparam int HW = obpc_pkg::HEAD_W;
    localparam int IW = obpc_pkg::IDX_W;

    obpc_pkg::t_cfg       w_cfg;
    obpc_pkg::t_queue_out w_q;
    logic                 w_pop;
    logic                 w_coll;
    logic                 w_stat;
    logic [IW-1:0]        w_idx;

    obpc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    obpc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_cmd        (i_s_axis_tuser),
        .i_pos_x      (i_s_axis_tdata[XW-1:0]),
        .i_pos_y      (i_s_axis_tdata[2*XW-1:XW]),
        .i_heading    (i_s_axis_tdata[2*XW+HW-1:2*XW]),
        .i_pose_index (i_s_axis_tdata[2*XW+HW+IW-1:2*XW+HW]),
        .i_pop        (w_pop),
        .o_q          (w_q)
    );

    obpc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_q          (w_q),
        .o_pop        (w_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_collided   (w_coll),
        .o_echo_index (w_idx),
        .o_status     (w_stat)
    );

    assign o_m_axis_tdata = {{(obpc_pkg::OUT_TDATA_W - obpc_pkg::OUT_FIELD_W){1'b0}},
                             w_stat, w_idx, w_coll};

endmodule

// File: src/obpc_cfg.sv
module obpc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [obpc_pkg::ADDR_W-1:0]   paddr,
    input  logic [obpc_pkg::APB_W-1:0]    pwdata,
    output logic [obpc_pkg::APB_W-1:0]    prdata,
    output logic                          pready,
    output obpc_pkg::t_cfg                o_cfg
);

    obpc_pkg::t_cfg      r_cfg;
    obpc_pkg::t_reg_idx  w_idx;
    logic [obpc_pkg::REG_W-1:0] w_wd;
    logic [obpc_pkg::REG_W-1:0] w_rd;
    logic                w_wr;

    assign pready = 1'b1;
    assign w_idx  = obpc_pkg::t_reg_idx'(paddr[obpc_pkg::ADDR_W-1:2]);
    assign w_wd   = pwdata[obpc_pkg::REG_W-1:0];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (w_idx)
                obpc_pkg::REG_FRONT:       r_cfg.front_length         <= w_wd;
                obpc_pkg::REG_SIDE:        r_cfg.side_half_width      <= w_wd;
                obpc_pkg::REG_REAR_ROAD:   r_cfg.rear_length_road     <= w_wd;
                obpc_pkg::REG_REAR_OBS:    r_cfg.rear_length_obstacle <= w_wd;
                obpc_pkg::REG_MARGIN_ROAD: r_cfg.margin_road          <= w_wd;
                obpc_pkg::REG_MARGIN_OBS:  r_cfg.margin_obstacle      <= w_wd;
                obpc_pkg::REG_MARGIN_ERR:  r_cfg.margin_error         <= w_wd;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            obpc_pkg::REG_FRONT:       w_rd = r_cfg.front_length;
            obpc_pkg::REG_SIDE:        w_rd = r_cfg.side_half_width;
            obpc_pkg::REG_REAR_ROAD:   w_rd = r_cfg.rear_length_road;
            obpc_pkg::REG_REAR_OBS:    w_rd = r_cfg.rear_length_obstacle;
            obpc_pkg::REG_MARGIN_ROAD: w_rd = r_cfg.margin_road;
            obpc_pkg::REG_MARGIN_OBS:  w_rd = r_cfg.margin_obstacle;
            obpc_pkg::REG_MARGIN_ERR:  w_rd = r_cfg.margin_error;
            default:                   w_rd = '0;
        endcase
    end

    assign prdata = obpc_pkg::APB_W'(w_rd);
    assign o_cfg  = r_cfg;

endmodule

// File: src/obpc_front.sv
module obpc_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [obpc_pkg::CMD_W-1:0]        i_cmd,
    input  logic [obpc_pkg::IN_COORD_W-1:0]   i_pos_x,
    input  logic [obpc_pkg::IN_COORD_W-1:0]   i_pos_y,
    input  logic [obpc_pkg::HEAD_W-1:0]       i_heading,
    input  logic [obpc_pkg::IDX_W-1:0]        i_pose_index,
    input  logic                              i_pop,
    output obpc_pkg::t_queue_out              o_q
);

    obpc_pkg::t_item            r_q [obpc_pkg::Q_DEPTH];
    logic [obpc_pkg::Q_AW-1:0]  r_wp;
    logic [obpc_pkg::Q_AW-1:0]  r_rp;
    logic [obpc_pkg::Q_CW-1:0]  r_cnt;
    obpc_pkg::t_item            w_item;
    logic                       w_push;
    logic                       w_pop;

    // sort the command into an operation
    always_comb begin
        w_item.pos_x      = i_pos_x[obpc_pkg::COORD_BITS-1:0];
        w_item.pos_y      = i_pos_y[obpc_pkg::COORD_BITS-1:0];
        w_item.heading    = i_heading;
        w_item.pose_index = i_pose_index;
        case (obpc_pkg::t_cmd'(i_cmd))
            obpc_pkg::CMD_CLR_ROAD:  w_item.op = obpc_pkg::OP_CLR_ROAD;
            obpc_pkg::CMD_CLR_OBS:   w_item.op = obpc_pkg::OP_CLR_OBS;
            obpc_pkg::CMD_LOAD_ROAD: w_item.op = obpc_pkg::OP_LOAD_ROAD;
            obpc_pkg::CMD_LOAD_OBS:  w_item.op = obpc_pkg::OP_LOAD_OBS;
            obpc_pkg::CMD_CHECK:     w_item.op = obpc_pkg::OP_CHECK;
            obpc_pkg::CMD_PATH:      w_item.op = obpc_pkg::OP_PATH;
            default:                 w_item.op = obpc_pkg::OP_NONE;
        endcase
    end

    assign o_ready = (r_cnt != obpc_pkg::Q_CW'(obpc_pkg::Q_DEPTH));
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    assign o_q.valid = (r_cnt != '0);
    assign o_q.item  = r_q[r_rp];

endmodule

// File: src/obpc_back.sv
`include "oriented_box_point_collision_top_macros.svh"

module obpc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  obpc_pkg::t_cfg                i_cfg,
    input  obpc_pkg::t_queue_out          i_q,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_collided,
    output logic [obpc_pkg::IDX_W-1:0]    o_echo_index,
    output logic                          o_status
);

    localparam int CB = obpc_pkg::COORD_BITS;
    localparam int ANC [4] = '{0, 3, 2, 1};
    localparam int TIP [4] = '{2, 1, 3, 0};

    obpc_pkg::t_state r_state, n_state;

    logic [obpc_pkg::ROAD_CW-1:0]     r_cnt_road;
    logic [obpc_pkg::OBS_CW-1:0]      r_cnt_obs;
    logic signed [CB-1:0]             r_px, r_py;
    logic [obpc_pkg::HEAD_W-1:0]      r_hd;
    logic [obpc_pkg::IDX_W-1:0]       r_idx;
    logic                             r_path;
    logic                             r_store;
    logic                             r_hit;
    logic [2:0]                       r_step;
    logic                             r_ang;

    logic signed [2*obpc_pkg::MUL_W-1:0] r_prod;
    logic signed [obpc_pkg::MUL_W-1:0]   r_z2, r_s, r_c;
    logic signed [obpc_pkg::PROD_W-1:0]  r_cp [6];
    logic signed [obpc_pkg::CORN_W-1:0]  r_cx [4];
    logic signed [obpc_pkg::CORN_W-1:0]  r_cy [4];
    logic signed [obpc_pkg::EDGE_W-1:0]  r_ex [4];
    logic signed [obpc_pkg::EDGE_W-1:0]  r_ey [4];

    logic [2*CB-1:0] r_mem_road [obpc_pkg::ROAD_CAP];
    logic [2*CB-1:0] r_mem_obs  [obpc_pkg::OBS_CAP];
    logic [2*CB-1:0] r_rd_road, r_rd_obs;

    logic [obpc_pkg::SCAN_CW-1:0]     r_issue;
    logic                             r_v_rd, r_v_d, r_v_m;
    logic signed [obpc_pkg::PD_W-1:0] r_dx [4];
    logic signed [obpc_pkg::PD_W-1:0] r_dy [4];
    logic signed [obpc_pkg::XP_W-1:0] r_m1 [4];
    logic signed [obpc_pkg::XP_W-1:0] r_m2 [4];

    logic                         r_out_valid, r_out_coll, r_out_stat;
    logic [obpc_pkg::IDX_W-1:0]   r_out_idx;

    logic                              w_out_free, w_is_check, w_issue, w_scan_done, w_fin_go;
    logic                              w_road_room, w_obs_room;
    logic [obpc_pkg::SCAN_CW-1:0]      w_scan_cnt;
    logic signed [obpc_pkg::MUL_W-1:0] w_mul_a, w_mul_b, w_sh, w_zq, w_sn, w_cs;
    logic signed [2*obpc_pkg::MUL_W-1:0] w_shf;
    logic [14:0]                       w_zz;
    logic signed [obpc_pkg::LEN_W-1:0] w_d, w_fa, w_w, w_r;
    logic [obpc_pkg::REG_W-1:0]        w_rear, w_marg, w_err;
    logic signed [obpc_pkg::OFS_W-1:0] w_ox [4];
    logic signed [obpc_pkg::OFS_W-1:0] w_oy [4];
    logic [2*CB-1:0]                   w_pt;
    logic signed [CB-1:0]              w_ptx, w_pty;
    logic signed [obpc_pkg::XP_W:0]    w_cr [4];
    logic [3:0]                        w_nn, w_np;
    logic                              w_hit;

    assign w_out_free  = !r_out_valid || i_ready;
    assign w_is_check  = (i_q.item.op == obpc_pkg::OP_CHECK) ||
                         (i_q.item.op == obpc_pkg::OP_PATH);
    assign w_road_room = r_cnt_road < obpc_pkg::ROAD_CW'(obpc_pkg::ROAD_CAP);
    assign w_obs_room  = r_cnt_obs < obpc_pkg::OBS_CW'(obpc_pkg::OBS_CAP);
    assign w_scan_cnt  = r_store ? obpc_pkg::SCAN_CW'(r_cnt_obs)
                                 : obpc_pkg::SCAN_CW'(r_cnt_road);

    // sine and cosine operands
    assign w_shf = r_prod >>> obpc_pkg::QSHIFT;
    assign w_sh  = w_shf[obpc_pkg::MUL_W-1:0];
    assign w_zz  = r_ang ? (obpc_pkg::QUARTER - {1'b0, r_hd[13:0]}) : {1'b0, r_hd[13:0]};
    assign w_zq  = {2'b00, w_zz, 16'h0000};

    always_comb begin
        case (r_hd[15:14])
            2'd0:    begin w_sn = r_s;  w_cs = r_c;  end
            2'd1:    begin w_sn = r_c;  w_cs = -r_s; end
            2'd2:    begin w_sn = -r_s; w_cs = -r_c; end
            default: begin w_sn = -r_c; w_cs = r_s;  end
        endcase
    end

    // box lengths for the store being checked
    always_comb begin
        w_rear = r_store ? i_cfg.rear_length_obstacle : i_cfg.rear_length_road;
        w_marg = r_store ? i_cfg.margin_obstacle : i_cfg.margin_road;
        w_err  = r_path ? i_cfg.margin_error : '0;
        w_d    = $signed({2'b00, w_marg}) - $signed({2'b00, w_err});
        w_fa   = $signed({2'b00, i_cfg.front_length}) + w_d;
        w_w    = $signed({2'b00, i_cfg.side_half_width}) + w_d;
        w_r    = $signed({2'b00, w_rear}) + w_d;
    end

    // corner offsets: lf, rf, lr, rr
    always_comb begin
        w_ox[0] = obpc_pkg::OFS_W'(r_cp[0]) - obpc_pkg::OFS_W'(r_cp[1]);
        w_oy[0] = obpc_pkg::OFS_W'(r_cp[2]) + obpc_pkg::OFS_W'(r_cp[3]);
        w_ox[1] = obpc_pkg::OFS_W'(r_cp[0]) + obpc_pkg::OFS_W'(r_cp[1]);
        w_oy[1] = obpc_pkg::OFS_W'(r_cp[2]) - obpc_pkg::OFS_W'(r_cp[3]);
        w_ox[2] = -obpc_pkg::OFS_W'(r_cp[4]) - obpc_pkg::OFS_W'(r_cp[1]);
        w_oy[2] = obpc_pkg::OFS_W'(r_cp[3]) - obpc_pkg::OFS_W'(r_cp[5]);
        w_ox[3] = obpc_pkg::OFS_W'(r_cp[1]) - obpc_pkg::OFS_W'(r_cp[4]);
        w_oy[3] = -obpc_pkg::OFS_W'(r_cp[5]) - obpc_pkg::OFS_W'(r_cp[3]);
    end

    assign w_pt  = r_store ? r_rd_obs : r_rd_road;
    assign w_ptx = w_pt[CB-1:0];
    assign w_pty = w_pt[2*CB-1:CB];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_cr[k] = (obpc_pkg::XP_W+1)'(r_m1[k]) - (obpc_pkg::XP_W+1)'(r_m2[k]);
            w_nn[k] = !w_cr[k][obpc_pkg::XP_W];
            w_np[k] = w_cr[k][obpc_pkg::XP_W] || (w_cr[k] == '0);
        end
        w_hit = ((w_nn[0] && w_nn[1]) || (w_np[0] && w_np[1])) &&
                ((w_nn[2] && w_nn[3]) || (w_np[2] && w_np[3]));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            obpc_pkg::ST_IDLE: begin
                if (i_q.valid && w_out_free && w_is_check) begin
                    n_state = obpc_pkg::ST_TRIG;
                end
            end
            obpc_pkg::ST_TRIG: begin
                if (r_step == 3'd6 && r_ang) begin
                    n_state = obpc_pkg::ST_CPROD;
                end
            end
            obpc_pkg::ST_CPROD: begin
                if (r_step == 3'd6) begin
                    n_state = obpc_pkg::ST_CORNER;
                end
            end
            obpc_pkg::ST_CORNER: n_state = obpc_pkg::ST_EDGE;
            obpc_pkg::ST_EDGE:   n_state = obpc_pkg::ST_SCAN;
            obpc_pkg::ST_SCAN: begin
                if (w_scan_done) begin
                    n_state = r_store ? obpc_pkg::ST_FIN : obpc_pkg::ST_CPROD;
                end
            end
            obpc_pkg::ST_FIN: begin
                if (w_out_free) begin
                    n_state = obpc_pkg::ST_IDLE;
                end
            end
            default: n_state = obpc_pkg::ST_IDLE;
        endcase
    end

    // control outputs and multiplier operands
    always_comb begin
        o_pop       = 1'b0;
        w_issue     = 1'b0;
        w_scan_done = 1'b0;
        w_fin_go    = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        case (r_state)
            obpc_pkg::ST_IDLE: o_pop = i_q.valid && w_out_free;
            obpc_pkg::ST_TRIG: begin
                case (r_step)
                    3'd0:    begin w_mul_a = w_zq;  w_mul_b = w_zq;                    end
                    3'd1:    begin w_mul_a = w_sh;  w_mul_b = obpc_pkg::SC9;           end
                    3'd2:    begin w_mul_a = r_z2;  w_mul_b = obpc_pkg::SC7 - w_sh;    end
                    3'd3:    begin w_mul_a = r_z2;  w_mul_b = obpc_pkg::SC5 - w_sh;    end
                    3'd4:    begin w_mul_a = r_z2;  w_mul_b = obpc_pkg::SC3 - w_sh;    end
                    3'd5:    begin w_mul_a = w_zq;  w_mul_b = obpc_pkg::SC1 - w_sh;    end
                    default: begin w_mul_a = '0;    w_mul_b = '0;                      end
                endcase
            end
            obpc_pkg::ST_CPROD: begin
                case (r_step)
                    3'd0:    begin w_mul_a = obpc_pkg::MUL_W'(w_fa); w_mul_b = w_cs; end
                    3'd1:    begin w_mul_a = obpc_pkg::MUL_W'(w_w);  w_mul_b = w_sn; end
                    3'd2:    begin w_mul_a = obpc_pkg::MUL_W'(w_fa); w_mul_b = w_sn; end
                    3'd3:    begin w_mul_a = obpc_pkg::MUL_W'(w_w);  w_mul_b = w_cs; end
                    3'd4:    begin w_mul_a = obpc_pkg::MUL_W'(w_r);  w_mul_b = w_cs; end
                    3'd5:    begin w_mul_a = obpc_pkg::MUL_W'(w_r);  w_mul_b = w_sn; end
                    default: begin w_mul_a = '0;                     w_mul_b = '0;   end
                endcase
            end
            obpc_pkg::ST_SCAN: begin
                w_issue     = r_issue < w_scan_cnt;
                w_scan_done = !w_issue && !r_v_rd && !r_v_d && !r_v_m;
            end
            obpc_pkg::ST_FIN: w_fin_go = w_out_free;
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= obpc_pkg::ST_IDLE;
            r_cnt_road  <= '0;
            r_cnt_obs   <= '0;
            r_step      <= '0;
            r_ang       <= 1'b0;
            r_store     <= 1'b0;
            r_hit       <= 1'b0;
            r_issue     <= '0;
            r_v_rd      <= 1'b0;
            r_v_d       <= 1'b0;
            r_v_m       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v_rd  <= w_issue;
            r_v_d   <= r_v_rd;
            r_v_m   <= r_v_d;
            if (o_pop) begin
                r_step  <= '0;
                r_ang   <= 1'b0;
                r_store <= 1'b0;
                r_hit   <= 1'b0;
                case (i_q.item.op)
                    obpc_pkg::OP_CLR_ROAD: r_cnt_road <= '0;
                    obpc_pkg::OP_CLR_OBS:  r_cnt_obs  <= '0;
                    obpc_pkg::OP_LOAD_ROAD: begin
                        if (w_road_room) begin
                            r_cnt_road <= r_cnt_road + 1'b1;
                        end
                    end
                    obpc_pkg::OP_LOAD_OBS: begin
                        if (w_obs_room) begin
                            r_cnt_obs <= r_cnt_obs + 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == obpc_pkg::ST_TRIG || r_state == obpc_pkg::ST_CPROD) begin
                if (r_step == 3'd6) begin
                    r_step <= '0;
                    r_ang  <= !r_ang;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
            if (r_state == obpc_pkg::ST_EDGE) begin
                r_issue <= '0;
            end else if (w_issue) begin
                r_issue <= r_issue + 1'b1;
            end
            if (r_v_m && w_hit) begin
                r_hit <= 1'b1;
            end
            if (w_scan_done) begin
                r_store <= 1'b1;
            end
            if (o_pop && !w_is_check) begin
                r_out_valid <= 1'b1;
            end else if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (o_pop) begin
            r_px   <= i_q.item.pos_x;
            r_py   <= i_q.item.pos_y;
            r_hd   <= i_q.item.heading;
            r_idx  <= i_q.item.pose_index;
            r_path <= (i_q.item.op == obpc_pkg::OP_PATH);
        end
        if (r_state == obpc_pkg::ST_TRIG) begin
            if (r_step == 3'd1) begin
                r_z2 <= w_sh;
            end
            if (r_step == 3'd6) begin
                if (w_shf > (2*obpc_pkg::MUL_W)'(obpc_pkg::Q30_ONE)) begin
                    if (r_ang) r_c <= obpc_pkg::Q30_ONE; else r_s <= obpc_pkg::Q30_ONE;
                end else if (w_shf < 0) begin
                    if (r_ang) r_c <= '0; else r_s <= '0;
                end else begin
                    if (r_ang) r_c <= w_sh; else r_s <= w_sh;
                end
            end
        end
        if (r_state == obpc_pkg::ST_CPROD && r_step != 3'd0) begin
            r_cp[r_step - 3'd1] <= r_prod[obpc_pkg::PROD_W-1:0];
        end
        // round to nearest, halves toward positive infinity
        if (r_state == obpc_pkg::ST_CORNER) begin
            for (int k = 0; k < 4; k++) begin
                r_cx[k] <= obpc_pkg::CORN_W'(r_px) +
                           obpc_pkg::CORN_W'((w_ox[k] +
                               obpc_pkg::OFS_W'(obpc_pkg::Q30_ONE >>> 1)) >>> obpc_pkg::QSHIFT);
                r_cy[k] <= obpc_pkg::CORN_W'(r_py) +
                           obpc_pkg::CORN_W'((w_oy[k] +
                               obpc_pkg::OFS_W'(obpc_pkg::Q30_ONE >>> 1)) >>> obpc_pkg::QSHIFT);
            end
        end
        if (r_state == obpc_pkg::ST_EDGE) begin
            for (int k = 0; k < 4; k++) begin
                r_ex[k] <= obpc_pkg::EDGE_W'(r_cx[TIP[k]] - r_cx[ANC[k]]);
                r_ey[k] <= obpc_pkg::EDGE_W'(r_cy[TIP[k]] - r_cy[ANC[k]]);
            end
        end
        for (int k = 0; k < 4; k++) begin
            r_dx[k] <= obpc_pkg::PD_W'(w_ptx) - obpc_pkg::PD_W'(r_cx[ANC[k]]);
            r_dy[k] <= obpc_pkg::PD_W'(w_pty) - obpc_pkg::PD_W'(r_cy[ANC[k]]);
            r_m1[k] <= obpc_pkg::XP_W'(r_ex[k]) * obpc_pkg::XP_W'(r_dy[k]);
            r_m2[k] <= obpc_pkg::XP_W'(r_dx[k]) * obpc_pkg::XP_W'(r_ey[k]);
        end
        if (o_pop && !w_is_check) begin
            r_out_coll <= 1'b0;
            r_out_idx  <= i_q.item.pose_index;
            r_out_stat <= ((i_q.item.op == obpc_pkg::OP_LOAD_ROAD) && !w_road_room) ||
                          ((i_q.item.op == obpc_pkg::OP_LOAD_OBS) && !w_obs_room);
        end else if (w_fin_go) begin
            r_out_coll <= r_hit;
            r_out_idx  <= r_idx;
            r_out_stat <= 1'b0;
        end
    end

    // point stores
    always_ff @(posedge i_clk) begin
        if (o_pop && i_q.item.op == obpc_pkg::OP_LOAD_ROAD && w_road_room) begin
            r_mem_road[r_cnt_road[obpc_pkg::ROAD_AW-1:0]] <= {i_q.item.pos_y, i_q.item.pos_x};
        end
        if (w_issue && !r_store) begin
            r_rd_road <= r_mem_road[r_issue[obpc_pkg::ROAD_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_q.item.op == obpc_pkg::OP_LOAD_OBS && w_obs_room) begin
            r_mem_obs[r_cnt_obs[obpc_pkg::OBS_AW-1:0]] <= {i_q.item.pos_y, i_q.item.pos_x};
        end
        if (w_issue && r_store) begin
            r_rd_obs <= r_mem_obs[r_issue[obpc_pkg::OBS_AW-1:0]];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_collided   = r_out_coll;
    assign o_echo_index = r_out_idx;
    assign o_status     = r_out_stat;

    `OBPC_ASSERT_ALWAYS(a_road_cap, i_clk, i_rst_n, r_cnt_road <= obpc_pkg::ROAD_CW'(obpc_pkg::ROAD_CAP), "road count over capacity")
    `OBPC_ASSERT_IMP(a_pipe_idle, i_clk, i_rst_n, r_state != obpc_pkg::ST_SCAN, !r_v_rd && !r_v_d && !r_v_m, "scan pipeline busy outside scan")
    `OBPC_ASSERT_IMP(a_stat_coll, i_clk, i_rst_n, r_out_valid, !(r_out_stat && r_out_coll), "drop status with collision")
    `OBPC_ASSERT_NXT(a_road_load, i_clk, i_rst_n, o_pop && i_q.item.op == obpc_pkg::OP_LOAD_ROAD && w_road_room, r_cnt_road == $past(r_cnt_road) + 1'b1, "road load not counted")

endmodule

// File: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_UNUSED_A = 3'd6;
    localparam logic [2:0] CMD_UNUSED_B = 3'd7;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;
    localparam longint K1 = 1686629713;
    localparam longint K3 = 693598668;
    localparam longint K5 = 85569306;
    localparam longint K7 = 5026995;
    localparam longint K9 = 172274;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] hdg;
        logic [15:0] idx;
        bit          typed;
        bit          collided;
        bit          status;
    } cmd_item_t;

    typedef struct {
        bit          collided;
        logic [15:0] idx;
        bit          status;
    } verdict_t;

    logic i_clk, i_rst_n;
    logic s_tvalid, s_tready;
    logic [obpc_pkg::IN_TDATA_W-1:0] s_tdata;
    logic [obpc_pkg::CMD_W-1:0] s_tuser;
    logic m_tvalid, m_tready;
    logic [obpc_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic psel, penable, pwrite, pready;
    logic [obpc_pkg::ADDR_W-1:0] paddr;
    logic [obpc_pkg::APB_W-1:0] pwdata, prdata;

    oriented_box_point_collision_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    cmd_item_t cmd_q[$];
    cmd_item_t cur_item;
    verdict_t verdict_q[$];
    longint road_x[$], road_y[$], obs_x[$], obs_y[$];
    logic [15:0] cfg [7];
    int errors = 0;
    int send_gap = 0, recv_hold = 0, long_hold = 0, idle_cnt = 0;
    bit quiet = 0;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // sine of a quarter turn fraction in q30
    function automatic longint quarter_sine(int unsigned z);
        longint zq, z2, p, s;
        zq = longint'(z) <<< 16;
        z2 = (zq * zq) >>> 30;
        p = K9;
        p = K7 - ((z2 * p) >>> 30);
        p = K5 - ((z2 * p) >>> 30);
        p = K3 - ((z2 * p) >>> 30);
        p = K1 - ((z2 * p) >>> 30);
        s = (zq * p) >>> 30;
        if (s > (longint'(1) <<< 30)) s = longint'(1) <<< 30;
        if (s < 0) s = 0;
        return s;
    endfunction

    function automatic longint q30_round(longint v);
        return (v + (longint'(1) <<< 29)) >>> 30;
    endfunction

    function automatic longint cross_z(longint ax, longint ay, longint bx, longint by,
                                       longint qx, longint qy);
        return (bx - ax) * (qy - ay) - (qx - ax) * (by - ay);
    endfunction

    function automatic bit same_sign(longint a, longint b);
        return (a >= 0 && b >= 0) || (a <= 0 && b <= 0);
    endfunction

    function automatic bit box_hits(bit obs, longint px, longint py, longint sn, longint cs,
                                    longint rear, longint d);
        longint fa, w, r, lfx, lfy, rfx, rfy, lrx, lry, rrx, rry, qx, qy;
        int n;
        fa = longint'(cfg[obpc_pkg::REG_FRONT]) + d;
        w = longint'(cfg[obpc_pkg::REG_SIDE]) + d;
        r = rear + d;
        lfx = px + q30_round(fa * cs - w * sn);
        lfy = py + q30_round(fa * sn + w * cs);
        rfx = px + q30_round(fa * cs + w * sn);
        rfy = py + q30_round(fa * sn - w * cs);
        lrx = px + q30_round(-r * cs - w * sn);
        lry = py + q30_round(-r * sn + w * cs);
        rrx = px + q30_round(-r * cs + w * sn);
        rry = py + q30_round(-r * sn - w * cs);
        n = obs ? obs_x.size() : road_x.size();
        for (int i = 0; i < n; i++) begin
            qx = obs ? obs_x[i] : road_x[i];
            qy = obs ? obs_y[i] : road_y[i];
            if (same_sign(cross_z(lfx, lfy, lrx, lry, qx, qy), cross_z(rrx, rry, rfx, rfy, qx, qy))
                && same_sign(cross_z(lrx, lry, rrx, rry, qx, qy),
                             cross_z(rfx, rfy, lfx, lfy, qx, qy)))
                return 1;
        end
        return 0;
    endfunction

    function automatic verdict_t collision_predict(cmd_item_t it);
        verdict_t v;
        longint px, py, s, c, sn, cs, dr, dob;
        px = longint'($signed(it.x));
        py = longint'($signed(it.y));
        v.collided = 0;
        v.idx = it.idx;
        v.status = 0;
        case (it.cmd)
            obpc_pkg::CMD_CLR_ROAD: begin
                road_x.delete();
                road_y.delete();
            end
            obpc_pkg::CMD_CLR_OBS: begin
                obs_x.delete();
                obs_y.delete();
            end
            obpc_pkg::CMD_LOAD_ROAD: begin
                if (road_x.size() < obpc_pkg::ROAD_CAP) begin
                    road_x = {road_x, px};
                    road_y = {road_y, py};
                end else v.status = 1;
            end
            obpc_pkg::CMD_LOAD_OBS: begin
                if (obs_x.size() < obpc_pkg::OBS_CAP) begin
                    obs_x = {obs_x, px};
                    obs_y = {obs_y, py};
                end else v.status = 1;
            end
            obpc_pkg::CMD_CHECK, obpc_pkg::CMD_PATH: begin
                dr = longint'(cfg[obpc_pkg::REG_MARGIN_ROAD]);
                dob = longint'(cfg[obpc_pkg::REG_MARGIN_OBS]);
                if (it.cmd == obpc_pkg::CMD_PATH) begin
                    dr -= longint'(cfg[obpc_pkg::REG_MARGIN_ERR]);
                    dob -= longint'(cfg[obpc_pkg::REG_MARGIN_ERR]);
                end
                s = quarter_sine(32'(it.hdg[13:0]));
                c = quarter_sine(32'd16384 - 32'(it.hdg[13:0]));
                case (it.hdg[15:14])
                    2'd0: begin sn = s;  cs = c;  end
                    2'd1: begin sn = c;  cs = -s; end
                    2'd2: begin sn = -s; cs = -c; end
                    default: begin sn = -c; cs = s; end
                endcase
                v.collided = box_hits(0, px, py, sn, cs,
                                      longint'(cfg[obpc_pkg::REG_REAR_ROAD]), dr)
                    || box_hits(1, px, py, sn, cs, longint'(cfg[obpc_pkg::REG_REAR_OBS]), dob);
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // sender
    always @(posedge i_clk) begin
        verdict_t v;
        if (!i_rst_n) begin
            s_tvalid <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                v = collision_predict(cur_item);
                if (cur_item.typed) begin
                    v.collided = cur_item.collided;
                    v.status = cur_item.status;
                end
                verdict_q = {verdict_q, v};
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 0;
                end else if (cmd_q.size() > 0) begin
                    cur_item = cmd_q.pop_front();
                    s_tvalid <= 1;
                    s_tuser <= cur_item.cmd;
                    s_tdata <= {cur_item.idx, cur_item.hdg, cur_item.y, cur_item.x};
                    if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 16);
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // receiver and result check
    always @(posedge i_clk) begin
        verdict_t w;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    report("unexpected result", longint'(m_tdata), 0);
                end else begin
                    w = verdict_q.pop_front();
                    if (m_tdata[0] !== w.collided)
                        report("collided", longint'(m_tdata[0]), longint'(w.collided));
                    if (m_tdata[16:1] !== w.idx)
                        report("echo_index", longint'(m_tdata[16:1]), longint'(w.idx));
                    if (m_tdata[17] !== w.status)
                        report("status", longint'(m_tdata[17]), longint'(w.status));
                end
            end
            if (long_hold > 0) begin
                long_hold--;
                m_tready <= 0;
            end else if (recv_hold > 0) begin
                recv_hold--;
                m_tready <= 0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                recv_hold = $urandom_range(0, 15);
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt > IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic apb_write(obpc_pkg::t_reg_idx r, logic [15:0] val);
        @(posedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= obpc_pkg::ADDR_W'(4 * int'(r));
        pwdata <= {16'($urandom_range(0, 65535)), val};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        cfg[r] = val;
        // read back the same register
        penable <= 0;
        pwrite <= 0;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        if (prdata[15:0] !== val) report("readback", longint'(prdata), longint'(val));
        psel <= 0;
        penable <= 0;
    endtask

    task automatic set_config(logic [15:0] f, logic [15:0] sd, logic [15:0] rr,
                              logic [15:0] ro, logic [15:0] mr, logic [15:0] mo,
                              logic [15:0] me);
        apb_write(obpc_pkg::REG_FRONT, f);
        apb_write(obpc_pkg::REG_SIDE, sd);
        apb_write(obpc_pkg::REG_REAR_ROAD, rr);
        apb_write(obpc_pkg::REG_REAR_OBS, ro);
        apb_write(obpc_pkg::REG_MARGIN_ROAD, mr);
        apb_write(obpc_pkg::REG_MARGIN_OBS, mo);
        apb_write(obpc_pkg::REG_MARGIN_ERR, me);
    endtask

    task automatic wait_drained();
        while (cmd_q.size() > 0 || s_tvalid || verdict_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_cmd(logic [2:0] c, logic [31:0] x, logic [31:0] y, logic [15:0] h);
        cmd_item_t it;
        it.cmd = c;
        it.x = x;
        it.y = y;
        it.hdg = h;
        it.idx = 16'($urandom_range(0, 65535));
        it.typed = 0;
        it.collided = 0;
        it.status = 0;
        cmd_q = {cmd_q, it};
    endtask

    // loads clustered around a pose and checks near it, mixed at random with clears and noise
    task automatic random_batch(int n, int spread);
        int cx, cy, r;
        logic [2:0] c;
        cx = $urandom;
        cy = $urandom;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                c = $urandom_range(0, 1) ? obpc_pkg::CMD_CLR_OBS : obpc_pkg::CMD_CLR_ROAD;
                add_cmd(c, $urandom, $urandom, 16'($urandom));
            end else if (r < 50) begin
                c = $urandom_range(0, 1) ? obpc_pkg::CMD_LOAD_OBS : obpc_pkg::CMD_LOAD_ROAD;
                add_cmd(c, cx + $urandom_range(0, 2 * spread) - spread,
                        cy + $urandom_range(0, 2 * spread) - spread, 16'($urandom));
            end else if (r < 85) begin
                c = $urandom_range(0, 1) ? obpc_pkg::CMD_PATH : obpc_pkg::CMD_CHECK;
                add_cmd(c, cx + $urandom_range(0, spread) - spread / 2,
                        cy + $urandom_range(0, spread) - spread / 2, 16'($urandom));
            end else if (r < 95) begin
                add_cmd(3'($urandom_range(2, 5)), $urandom, $urandom, 16'($urandom));
            end else begin
                add_cmd($urandom_range(0, 1) ? CMD_UNUSED_B : CMD_UNUSED_A,
                        $urandom, $urandom, 16'($urandom));
            end
        end
    endtask

    cmd_item_t dir_tab [20] = '{
        '{obpc_pkg::CMD_CHECK,     32'd0,         32'd0,         16'd0,    16'd1,    1, 0, 0},
        '{obpc_pkg::CMD_LOAD_ROAD, 32'd0,         32'd0,         16'hffff, 16'd2,    1, 0, 0},
        '{obpc_pkg::CMD_CHECK,     32'd0,         32'd0,         16'd0,    16'd3,    1, 1, 0},
        '{obpc_pkg::CMD_PATH,      32'd1000,      32'd0,         16'h4000, 16'd4,    1, 1, 0},
        '{CMD_UNUSED_A,            32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff, 1, 0, 0},
        '{CMD_UNUSED_B,            32'd0,         32'd0,         16'd0,    16'd0,    1, 0, 0},
        '{obpc_pkg::CMD_CLR_ROAD,  32'hffff_ffff, 32'h0,         16'd0,    16'd7,    1, 0, 0},
        '{obpc_pkg::CMD_CHECK,     32'd0,         32'd0,         16'd0,    16'd8,    1, 0, 0},
        '{obpc_pkg::CMD_LOAD_OBS,  32'h8000_0000, 32'h7fff_ffff, 16'd0,    16'd9,    1, 0, 0},
        '{obpc_pkg::CMD_CHECK,     32'h8000_0000, 32'h7fff_ffff, 16'h8000, 16'd10,   1, 1, 0},
        '{obpc_pkg::CMD_CHECK,     32'h7fff_ffff, 32'h8000_0000, 16'hc000, 16'd11,   1, 1, 0},
        '{obpc_pkg::CMD_CLR_OBS,   32'd0,         32'd0,         16'hffff, 16'd12,   1, 0, 0},
        '{obpc_pkg::CMD_LOAD_ROAD, 32'd100,       32'd50,        16'd0,    16'd13,   0, 0, 0},
        '{obpc_pkg::CMD_LOAD_OBS,  32'hffff_ff00, 32'd20,        16'd0,    16'd14,   0, 0, 0},
        '{obpc_pkg::CMD_CHECK,     32'd90,        32'd40,        16'h2000, 16'd15,   0, 0, 0},
        '{obpc_pkg::CMD_PATH,      32'hffff_ff10, 32'd10,        16'h6000, 16'd16,   0, 0, 0},
        '{obpc_pkg::CMD_CHECK,     32'd0,         32'd0,         16'h3fff, 16'd17,   0, 0, 0},
        '{obpc_pkg::CMD_PATH,      32'd0,         32'd0,         16'hbfff, 16'd18,   0, 0, 0},
        '{obpc_pkg::CMD_CLR_ROAD,  32'd0,         32'd0,         16'd0,    16'd19,   1, 0, 0},
        '{obpc_pkg::CMD_CLR_OBS,   32'd0,         32'd0,         16'd0,    16'd20,   1, 0, 0}
    };

    initial begin
        i_rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        for (int i = 0; i < 7; i++) cfg[i] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // zero sized box right after reset
        foreach (dir_tab[i]) begin
            if (i == 12) begin
                wait_drained();
                set_config(16'd300, 16'd200, 16'd100, 16'd150, 16'd20, 16'd30, 16'd40);
            end
            cmd_q = {cmd_q, dir_tab[i]};
        end
        wait_drained();

        set_config(16'($urandom_range(200, 3000)), 16'($urandom_range(100, 1500)),
                   16'($urandom_range(200, 3000)), 16'($urandom_range(200, 3000)),
                   16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                   16'($urandom_range(0, 300)));
        long_hold = 400;
        random_batch(30, 6000);
        wait_drained();

        set_config(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        add_cmd(obpc_pkg::CMD_CLR_ROAD, 32'd0, 32'd0, 16'd0);
        add_cmd(obpc_pkg::CMD_CLR_OBS, 32'd0, 32'd0, 16'd0);
        random_batch(28, 400000);
        wait_drained();

        // error margin above both margins gives a shrunken or inverted box
        set_config(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 1000)),
                   16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
                   16'($urandom_range(0, 500)), 16'($urandom_range(0, 500)),
                   16'($urandom_range(1000, 65535)));
        random_batch(30, 4000);
        wait_drained();

        quiet = 1;
        set_config(16'($urandom), 16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                   16'($urandom_range(0, 3000)), 16'($urandom), 16'($urandom),
                   16'($urandom_range(0, 5000)));
        random_batch(30, 8000);
        wait_drained();

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+src
src/obpc_pkg.sv
src/obpc_cfg.sv
src/obpc_front.sv
src/obpc_back.sv
src/oriented_box_point_collision_top.sv
verif/tb.sv
